@@ rtl/rabbit_pkg.sv @@
`timescale 1ns / 1ps
package rabbit_pkg;

   localparam logic [1:0] ACT_KEY   = 2'd0;
   localparam logic [1:0] ACT_IV    = 2'd1;
   localparam logic [1:0] ACT_CRYPT = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   localparam logic [31:0] A0 = 32'h4D34D34D;
   localparam logic [31:0] A1 = 32'hD34D34D3;
   localparam logic [31:0] A2 = 32'h34D34D34;

   localparam logic [1:0] REG_KEY_LOW  = 2'd0;
   localparam logic [1:0] REG_KEY_HIGH = 2'd1;
   localparam logic [1:0] REG_IV       = 2'd2;

   // decoded command handed from front to back
   typedef struct packed {
      logic [1:0]  action;
      logic        skip;      // crypt with zero count: pass data through
      logic [15:0] byte_en;
      logic [63:0] data_low;
      logic [63:0] data_high;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_COUNTER, ST_GSQ, ST_MIX, ST_FINISH, ST_OUT
   } eng_state_type;

   function automatic logic [31:0] rotl16(input logic [31:0] v);
      return {v[15:0], v[31:16]};
   endfunction

   function automatic logic [31:0] a_const(input logic [2:0] i);
      logic [31:0] r;
      case (i)
         3'd0, 3'd3, 3'd6: r = A0;
         3'd1, 3'd4, 3'd7: r = A1;
         default:          r = A2;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/rabbit_front.sv @@
`timescale 1ns / 1ps
module rabbit_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [1:0]            in_action,
   input  logic [63:0]           in_data_low,
   input  logic [63:0]           in_data_high,
   input  logic [4:0]            in_byte_count,
   output logic                  q_valid,
   input  logic                  q_ready,
   output rabbit_pkg::cmd_type   q_cmd
);
   import rabbit_pkg::*;

   // two-entry command queue
   cmd_type    slot_ff [2];
   cmd_type    slot_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       push, pop;
   logic [15:0] en;

   // classify: byte enables from count (saturate at 16)
   always_comb begin
      for (int b = 0; b < 16; b++) begin
         en[b] = (in_byte_count > 5'(b));
      end
      slot_in.action    = in_action;
      slot_in.skip      = (in_byte_count == 5'd0);
      slot_in.byte_en   = en;
      slot_in.data_low  = in_data_low;
      slot_in.data_high = in_data_high;
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_cmd    = slot_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= slot_in;
      end
   end

endmodule

@@ rtl/rabbit_engine.sv @@
`timescale 1ns / 1ps
module rabbit_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  rabbit_pkg::cmd_type   q_cmd,
   input  logic [63:0]           key_low,
   input  logic [63:0]           key_high,
   input  logic [63:0]           iv_value,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [63:0]           out_low,
   output logic [63:0]           out_high
);
   import rabbit_pkg::*;

   eng_state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [31:0] mx_ff [8], mc_ff [8];
   logic        mcy_ff;
   logic [31:0] wx_ff [8], wx_in [8];
   logic [31:0] wc_ff [8], wc_in [8];
   logic        wcy_ff, wcy_in;
   logic [31:0] g_ff [8], g_in [8];
   logic [2:0]  idx_ff, idx_in;       // lane for counter and square steps
   logic [2:0]  rnd_ff, rnd_in;       // rounds left
   logic        mupd;                 // copy work into master after key setup
   logic [63:0] olo_ff, olo_in, ohi_ff, ohi_in;
   logic        ov_ff, ov_in;
   logic [32:0] csum;
   logic [31:0] sqin;
   logic [63:0] sq;
   logic [31:0] k0, k1, k2, k3, s0, s1, s2, s3, sv [4];
   logic [31:0] w0, w1, w2, w3;
   logic [63:0] ksw_lo, ksw_hi;
   logic [63:0] kslo, kshi;

   assign k0 = key_low[31:0];
   assign k1 = key_low[63:32];
   assign k2 = key_high[31:0];
   assign k3 = key_high[63:32];
   assign s0 = iv_value[31:0];
   assign s2 = iv_value[63:32];
   assign s1 = {s2[31:16], s0[31:16]};
   assign s3 = {s2[15:0], s0[15:0]};
   assign sv[0] = s0;
   assign sv[1] = s1;
   assign sv[2] = s2;
   assign sv[3] = s3;

   // one counter lane and one squarer per cycle
   assign csum = {1'b0, wc_ff[idx_ff]} + {1'b0, a_const(idx_ff)} + 33'(wcy_ff);
   assign sqin = wx_ff[idx_ff] + wc_ff[idx_ff];
   assign sq   = {32'd0, sqin} * {32'd0, sqin};

   // keystream extraction
   assign w0 = wx_ff[0] ^ (wx_ff[5] >> 16) ^ (wx_ff[3] << 16);
   assign w1 = wx_ff[2] ^ (wx_ff[7] >> 16) ^ (wx_ff[5] << 16);
   assign w2 = wx_ff[4] ^ (wx_ff[1] >> 16) ^ (wx_ff[7] << 16);
   assign w3 = wx_ff[6] ^ (wx_ff[3] >> 16) ^ (wx_ff[1] << 16);
   assign ksw_lo = {w1, w0};
   assign ksw_hi = {w3, w2};
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         kslo[b*8 +: 8] = cmd_ff.byte_en[b] ? ksw_lo[b*8 +: 8] : 8'd0;
         kshi[b*8 +: 8] = cmd_ff.byte_en[b+8] ? ksw_hi[b*8 +: 8] : 8'd0;
      end
   end

   assign q_ready   = (state_ff == ST_IDLE);
   assign out_valid = ov_ff;
   assign out_low   = olo_ff;
   assign out_high  = ohi_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      wx_in    = wx_ff;
      wc_in    = wc_ff;
      wcy_in   = wcy_ff;
      g_in     = g_ff;
      idx_in   = idx_ff;
      rnd_in   = rnd_ff;
      olo_in   = olo_ff;
      ohi_in   = ohi_ff;
      ov_in    = ov_ff && !out_ready;
      mupd     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cmd_in = q_cmd;
               idx_in = 3'd0;
               unique case (q_cmd.action)
                  ACT_KEY: begin
                     wx_in[0] = k0; wx_in[2] = k1; wx_in[4] = k2; wx_in[6] = k3;
                     wx_in[1] = {k3[15:0], k2[31:16]};
                     wx_in[3] = {k0[15:0], k3[31:16]};
                     wx_in[5] = {k1[15:0], k0[31:16]};
                     wx_in[7] = {k2[15:0], k1[31:16]};
                     wc_in[0] = rotl16(k2); wc_in[2] = rotl16(k3);
                     wc_in[4] = rotl16(k0); wc_in[6] = rotl16(k1);
                     wc_in[1] = {k0[31:16], k1[15:0]};
                     wc_in[3] = {k1[31:16], k2[15:0]};
                     wc_in[5] = {k2[31:16], k3[15:0]};
                     wc_in[7] = {k3[31:16], k0[15:0]};
                     wcy_in   = 1'b0;
                     rnd_in   = 3'd4;
                     state_in = ST_COUNTER;
                  end
                  ACT_IV: begin
                     for (int i = 0; i < 8; i++) begin
                        wx_in[i] = mx_ff[i];
                        wc_in[i] = mc_ff[i] ^ sv[i % 4];
                     end
                     wcy_in   = mcy_ff;
                     rnd_in   = 3'd4;
                     state_in = ST_COUNTER;
                  end
                  ACT_CRYPT: begin
                     rnd_in   = 3'd1;
                     state_in = q_cmd.skip ? ST_FINISH : ST_COUNTER;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_COUNTER: begin
            wc_in[idx_ff] = csum[31:0];
            wcy_in        = csum[32];
            idx_in        = idx_ff + 3'd1;
            if (idx_ff == 3'd7) state_in = ST_GSQ;
         end
         ST_GSQ: begin
            g_in[idx_ff] = sq[63:32] ^ sq[31:0];
            idx_in       = idx_ff + 3'd1;
            if (idx_ff == 3'd7) state_in = ST_MIX;
         end
         ST_MIX: begin
            for (int i = 0; i < 8; i += 2) begin
               wx_in[i]   = g_ff[i] + rotl16(g_ff[(i+7)%8]) + rotl16(g_ff[(i+6)%8]);
               wx_in[i+1] = g_ff[i+1] + {g_ff[i][23:0], g_ff[i][31:24]}
                            + g_ff[(i+7)%8];
            end
            rnd_in   = rnd_ff - 3'd1;
            state_in = (rnd_ff == 3'd1) ? ST_FINISH : ST_COUNTER;
            if (rnd_ff == 3'd1 && cmd_ff.action == ACT_KEY) begin
               for (int i = 0; i < 8; i++) wc_in[i] = wc_ff[i] ^ wx_in[(i+4)%8];
            end
         end
         ST_FINISH: begin
            // wait here while the previous response is still held
            if (!ov_ff) begin
               mupd     = (cmd_ff.action == ACT_KEY);
               olo_in   = 64'd0;
               ohi_in   = 64'd0;
               if (cmd_ff.action == ACT_CRYPT) begin
                  olo_in = cmd_ff.data_low ^ (cmd_ff.skip ? 64'd0 : kslo);
                  ohi_in = cmd_ff.data_high ^ (cmd_ff.skip ? 64'd0 : kshi);
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!ov_ff) begin
               ov_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
         mcy_ff   <= 1'b0;
         wcy_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            mx_ff[i] <= 32'd0;
            mc_ff[i] <= 32'd0;
            wx_ff[i] <= 32'd0;
            wc_ff[i] <= 32'd0;
         end
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         wcy_ff   <= wcy_in;
         wx_ff    <= wx_in;
         wc_ff    <= wc_in;
         if (mupd) begin
            mx_ff  <= wx_ff;
            mc_ff  <= wc_ff;
            mcy_ff <= wcy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      g_ff   <= g_in;
      idx_ff <= idx_in;
      rnd_ff <= rnd_in;
      olo_ff <= olo_in;
      ohi_ff <= ohi_in;
   end

endmodule

@@ rtl/rabbit_stream_cipher.sv @@
`timescale 1ns / 1ps
// Rabbit stream cipher, 128-bit key, 64-bit IV.
// Config (csr_*): APB, 8-byte registers: 0x0 key_low, 0x8 key_high, 0x10 iv_value.
// Write only while idle. pready is always high.
// Request stream (req_*): tuser = action (0 key setup, 1 IV setup, 2 crypt),
// tdata = data_low, data_high, byte_count. One response per request on rsp_*;
// tdata = out_low, out_high (zero for setup items).
// A two-entry command queue decouples request intake from the round engine.
// The engine runs a round as 8 counter-lane steps, 8 squarer steps
// (one 32x32 multiplier shared by the lanes) and 1 mix step.
// A crypt item runs one round, a setup item four rounds, and a crypt with
// zero byte count or an unused action runs none. The serial round engine
// takes a new item only after it has issued the response to the last one.
// Reset clears all cipher state, registers and the queue.
// When rsp_tready is low the response holds in its register; the engine runs
// the next item up to its result and waits, the queue takes two more
// requests, then req_tready drops.
module rabbit_stream_cipher (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [135:0]  req_tdata,   // data_low[63:0], data_high[127:64], byte_count[132:128]
   input  logic [1:0]    req_tuser,   // action
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,   // out_low[63:0], out_high[127:64]
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [4:0]    csr_paddr,
   input  logic [63:0]   csr_pwdata,
   output logic [63:0]   csr_prdata,
   output logic          csr_pready
);
   import rabbit_pkg::*;

   logic [63:0] key_low_ff, key_high_ff, iv_ff;
   logic        wr;
   logic [1:0]  ridx;
   logic        q_valid, q_ready;
   cmd_type     q_cmd;
   logic [63:0] olo, ohi;

   assign csr_pready = 1'b1;
   assign ridx = csr_paddr[4:3];
   assign wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= 64'd0;
         key_high_ff <= 64'd0;
         iv_ff       <= 64'd0;
      end else if (wr) begin
         unique case (ridx)
            REG_KEY_LOW:  key_low_ff  <= csr_pwdata;
            REG_KEY_HIGH: key_high_ff <= csr_pwdata;
            REG_IV:       iv_ff       <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         REG_KEY_LOW:  csr_prdata = key_low_ff;
         REG_KEY_HIGH: csr_prdata = key_high_ff;
         REG_IV:       csr_prdata = iv_ff;
         default:      csr_prdata = 64'd0;
      endcase
   end

   rabbit_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_action     (req_tuser),
      .in_data_low   (req_tdata[63:0]),
      .in_data_high  (req_tdata[127:64]),
      .in_byte_count (req_tdata[132:128]),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_cmd         (q_cmd)
   );

   rabbit_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_cmd     (q_cmd),
      .key_low   (key_low_ff),
      .key_high  (key_high_ff),
      .iv_value  (iv_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_low   (olo),
      .out_high  (ohi)
   );

   assign rsp_tdata = {ohi, olo};

endmodule

@@ rtl/rabbit_checker.sv @@
`timescale 1ns / 1ps
module rabbit_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         csr_pready
);
   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // no response straight after reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response after reset");

   // a taken response is never followed by another in the next cycle
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("back-to-back responses");

   // request ready only drops after an item was taken
   a_full: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid && req_tready))
      else $error("request ready dropped without an item");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind rabbit_stream_cipher rabbit_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

@@ bench/tb_rabbit_stream_cipher.sv @@
`timescale 1ns / 1ps
module tb_rabbit_stream_cipher;
   import rabbit_pkg::*;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [135:0]  req_tdata;   // data_low[63:0], data_high[127:64], byte_count[132:128]
   logic [1:0]    req_tuser;   // action
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [127:0]  rsp_tdata;   // out_low[63:0], out_high[127:64]
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [4:0]    csr_paddr;
   logic [63:0]   csr_pwdata;
   logic [63:0]   csr_prdata;
   logic          csr_pready;

   rabbit_stream_cipher dut (.*);

   // cipher instance held by the predictor
   typedef struct {
      logic [31:0] x [8];
      logic [31:0] c [8];
      logic        carry;
   } cipher_inst_type;

   typedef struct {
      logic [1:0]  action;
      logic [63:0] dlo;
      logic [63:0] dhi;
      logic [4:0]  count;
      logic        known;   // expected value typed in below
      logic [63:0] olo;
      logic [63:0] ohi;
   } stim_row_type;

   cipher_inst_type master_inst, work_inst;
   logic [63:0]  key_lo_reg, key_hi_reg, iv_reg;
   logic [127:0] expected_blocks [$];
   int           fail_count;
   int           sent_count;
   bit           hold_rsp;
   bit           stim_done;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("tb_rabbit_stream_cipher failed");
      $finish;
   end

   function automatic logic [31:0] rot32(logic [31:0] v, int r);
      return (v << r) | (v >> (32 - r));
   endfunction

   function automatic logic [31:0] square_fold(logic [31:0] v);
      logic [63:0] sq;
      sq = {32'd0, v} * {32'd0, v};
      return sq[63:32] ^ sq[31:0];
   endfunction

   function automatic logic [31:0] a_of(int i);
      case (i % 3)
         0: return 32'h4D34D34D;
         1: return 32'hD34D34D3;
         default: return 32'h34D34D34;
      endcase
   endfunction

   task automatic next_round(ref cipher_inst_type s);
      logic [32:0] sum;
      logic [31:0] g [8];
      for (int i = 0; i < 8; i++) begin
         sum = {1'b0, s.c[i]} + {1'b0, a_of(i)} + s.carry;
         s.c[i] = sum[31:0];
         s.carry = sum[32];
      end
      for (int i = 0; i < 8; i++) g[i] = square_fold(s.x[i] + s.c[i]);
      for (int i = 0; i < 8; i += 2) begin
         s.x[i]   = g[i] + rot32(g[(i + 7) & 7], 16) + rot32(g[(i + 6) & 7], 16);
         s.x[i+1] = g[i+1] + rot32(g[i], 8) + g[(i + 7) & 7];
      end
   endtask

   // compute expected output block for one item, updating cipher state
   task automatic predict_block(input logic [1:0] act, input logic [63:0] dlo,
                                input logic [63:0] dhi, input logic [4:0] cnt,
                                output logic [127:0] res);
      logic [31:0] k0, k1, k2, k3, w [4], sv [4];
      logic [63:0] ks_lo, ks_hi, m_lo, m_hi;
      int n;
      res = '0;
      k0 = key_lo_reg[31:0]; k1 = key_lo_reg[63:32];
      k2 = key_hi_reg[31:0]; k3 = key_hi_reg[63:32];
      case (act)
         ACT_KEY: begin
            master_inst.x[0] = k0; master_inst.x[2] = k1;
            master_inst.x[4] = k2; master_inst.x[6] = k3;
            master_inst.x[1] = {k3[15:0], k2[31:16]};
            master_inst.x[3] = {k0[15:0], k3[31:16]};
            master_inst.x[5] = {k1[15:0], k0[31:16]};
            master_inst.x[7] = {k2[15:0], k1[31:16]};
            master_inst.c[0] = rot32(k2, 16); master_inst.c[2] = rot32(k3, 16);
            master_inst.c[4] = rot32(k0, 16); master_inst.c[6] = rot32(k1, 16);
            master_inst.c[1] = {k0[31:16], k1[15:0]};
            master_inst.c[3] = {k1[31:16], k2[15:0]};
            master_inst.c[5] = {k2[31:16], k3[15:0]};
            master_inst.c[7] = {k3[31:16], k0[15:0]};
            master_inst.carry = 0;
            repeat (4) next_round(master_inst);
            for (int i = 0; i < 8; i++)
               master_inst.c[i] ^= master_inst.x[(i + 4) & 7];
            work_inst = master_inst;
         end
         ACT_IV: begin
            sv[0] = iv_reg[31:0];
            sv[2] = iv_reg[63:32];
            sv[1] = {sv[2][31:16], sv[0][31:16]};
            sv[3] = {sv[2][15:0], sv[0][15:0]};
            for (int i = 0; i < 8; i++) begin
               work_inst.c[i] = master_inst.c[i] ^ sv[i & 3];
               work_inst.x[i] = master_inst.x[i];
            end
            work_inst.carry = master_inst.carry;
            repeat (4) next_round(work_inst);
         end
         ACT_CRYPT: begin
            n = cnt;
            if (n == 0) begin
               res = {dhi, dlo};
            end else begin
               if (n > 16) n = 16;
               next_round(work_inst);
               for (int i = 0; i < 4; i++) w[i] = work_inst.x[2*i];
               w[0] ^= (work_inst.x[5] >> 16) ^ (work_inst.x[3] << 16);
               w[1] ^= (work_inst.x[7] >> 16) ^ (work_inst.x[5] << 16);
               w[2] ^= (work_inst.x[1] >> 16) ^ (work_inst.x[7] << 16);
               w[3] ^= (work_inst.x[3] >> 16) ^ (work_inst.x[1] << 16);
               ks_lo = {w[1], w[0]};
               ks_hi = {w[3], w[2]};
               m_lo = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 1);
               m_hi = (n > 8) ? ((n >= 16) ? '1 : ((64'd1 << (8 * (n - 8))) - 1)) : '0;
               res = {dhi ^ (ks_hi & m_hi), dlo ^ (ks_lo & m_lo)};
            end
         end
         default: res = '0;
      endcase
   endtask

   // APB write: setup then access
   task automatic csr_write(input logic [1:0] idx, input logic [63:0] val);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      case (idx)
         REG_KEY_LOW:  key_lo_reg = val;
         REG_KEY_HIGH: key_hi_reg = val;
         default:      iv_reg = val;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drain();
      req_tvalid <= 0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send_item(input logic [1:0] act, input logic [63:0] dlo,
                            input logic [63:0] dhi, input logic [4:0] cnt,
                            input bit allow_gap);
      logic [127:0] res;
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= act;
      req_tdata  <= {3'd0, cnt, dhi, dlo};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_block(act, dlo, dhi, cnt, res);
      expected_blocks.push_back(res);
      sent_count++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [1:0] rand_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)  return ACT_KEY;
      if (r < 18) return ACT_IV;
      if (r < 96) return ACT_CRYPT;
      return ACT_NONE;
   endfunction

   function automatic logic [4:0] rand_count();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 5'd0;
      if (r == 1) return 5'($urandom_range(17, 31));
      if (r == 2) return 5'd16;
      return 5'($urandom_range(1, 16));
   endfunction

   // response checker
   always @(posedge clock) begin
      logic [127:0] exp_blk;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_blocks.size() == 0) begin
            $error("unexpected item: out_low=%h out_high=%h", rsp_tdata[63:0],
                   rsp_tdata[127:64]);
            fail_count++;
         end else begin
            exp_blk = expected_blocks.pop_front();
            if (rsp_tdata[63:0] !== exp_blk[63:0]) begin
               $error("out_low expected %h actual %h", exp_blk[63:0], rsp_tdata[63:0]);
               fail_count++;
            end
            if (rsp_tdata[127:64] !== exp_blk[127:64]) begin
               $error("out_high expected %h actual %h", exp_blk[127:64],
                      rsp_tdata[127:64]);
               fail_count++;
            end
         end
      end
   end

   // receiver: random stalls, plus a forced long hold-off on request
   initial begin
      int stall;
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end else if (!stim_done && $urandom_range(0, 4) == 0) begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 3);
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1;
      end
   end

   // directed rows; known results only where obvious
   stim_row_type dir_rows [] = '{
      '{ACT_NONE,  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 1, 64'd0, 64'd0},
      '{ACT_CRYPT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd0,  1,
        64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210},
      '{ACT_CRYPT, 64'd0, 64'd0, 5'd16, 0, 64'd0, 64'd0},
      '{ACT_KEY,   64'hFFFF_FFFF_FFFF_FFFF, 64'd5, 5'd31, 1, 64'd0, 64'd0},
      '{ACT_CRYPT, 64'd0, 64'd0, 5'd16, 0, 64'd0, 64'd0},
      '{ACT_IV,    64'd0, 64'd0, 5'd1,  1, 64'd0, 64'd0},
      '{ACT_CRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd1, 0, 64'd0, 64'd0},
      '{ACT_CRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd8, 0, 64'd0, 64'd0},
      '{ACT_CRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd9, 0, 64'd0, 64'd0},
      '{ACT_CRYPT, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 5'd15, 0, 64'd0, 64'd0},
      '{ACT_CRYPT, 64'd0, 64'd0, 5'd17, 0, 64'd0, 64'd0},
      '{ACT_CRYPT, 64'd0, 64'd0, 5'd31, 0, 64'd0, 64'd0},
      '{ACT_NONE,  64'd1, 64'd2, 5'd3,  1, 64'd0, 64'd0},
      '{ACT_IV,    64'd0, 64'd0, 5'd0,  1, 64'd0, 64'd0},
      '{ACT_CRYPT, 64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888, 5'd16, 0, 64'd0, 64'd0}
   };

   initial begin
      logic [127:0] pred;
      fail_count = 0;
      sent_count = 0;
      hold_rsp   = 0;
      stim_done  = 0;
      key_lo_reg = '0; key_hi_reg = '0; iv_reg = '0;
      for (int i = 0; i < 8; i++) begin
         master_inst.x[i] = '0; master_inst.c[i] = '0;
         work_inst.x[i] = '0;   work_inst.c[i] = '0;
      end
      master_inst.carry = 0; work_inst.carry = 0;
      reset = 1;
      req_tvalid = 0; req_tdata = '0; req_tuser = ACT_NONE;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed part; config changed between phases while idle
      foreach (dir_rows[i]) begin
         if (i == 3) begin
            wait_drain();
            csr_write(REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
            csr_write(REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
            csr_write(REG_IV, 64'hFFFF_FFFF_FFFF_FFFF);
         end
         if (i == 13) begin
            wait_drain();
            csr_write(REG_IV, 64'd0);
         end
         send_item(dir_rows[i].action, dir_rows[i].dlo, dir_rows[i].dhi,
                   dir_rows[i].count, 0);
         if (dir_rows[i].known) begin
            pred = expected_blocks[$];
            if (pred[63:0] !== dir_rows[i].olo) begin
               $error("out_low expected %h actual %h", dir_rows[i].olo, pred[63:0]);
               fail_count++;
            end
            if (pred[127:64] !== dir_rows[i].ohi) begin
               $error("out_high expected %h actual %h", dir_rows[i].ohi, pred[127:64]);
               fail_count++;
            end
         end
      end

      // random phases, each with a fresh configuration
      for (int ph = 0; ph < 9; ph++) begin
         wait_drain();
         csr_write(REG_KEY_LOW, (ph == 0) ? 64'd0 : rand64());
         csr_write(REG_KEY_HIGH, (ph == 0) ? 64'd0 : rand64());
         csr_write(REG_IV, (ph == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : rand64());
         send_item(ACT_KEY, rand64(), rand64(), rand_count(), 0);
         send_item(ACT_IV, rand64(), rand64(), rand_count(), 0);
         if (ph == 2) hold_rsp = 1;
         for (int k = 0; k < 48; k++) begin
            send_item(rand_action(), rand64(), rand64(), rand_count(), 1);
            if (ph == 4 && k == 20) wait_drain();
         end
      end
      stim_done = 1;

      wait_drain();
      if (fail_count == 0 && expected_blocks.size() == 0)
         $display("tb_rabbit_stream_cipher passed");
      else
         $display("tb_rabbit_stream_cipher failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/rabbit_pkg.sv
rtl/rabbit_front.sv
rtl/rabbit_engine.sv
rtl/rabbit_stream_cipher.sv
rtl/rabbit_checker.sv
bench/tb_rabbit_stream_cipher.sv
